/* rtl/inode_block_map_top_assert.svh */
// Assertion macros for the inode block map RTL.
// Each macro assumes a clock named clk and an active-low reset named arst_n.
`ifndef INODE_BLOCK_MAP_TOP_ASSERT_SVH
`define INODE_BLOCK_MAP_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define IBMAP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define IBMAP_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define IBMAP_ASSERT(lbl, prop, msg)
`define IBMAP_NEVER(lbl, cond, msg)

`endif

`endif

/* rtl/ibmap_pkg.sv */
`timescale 1ns / 1ps

package ibmap_pkg;

	localparam int POS_W  = 13;
	localparam int BLK_W  = 32;
	localparam int STAT_W = 2;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_APPEND = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic             opcode;
		logic [POS_W-1:0] position;
		logic [BLK_W-1:0] new_block;
	} in_t;

	typedef struct packed {
		logic [BLK_W-1:0]  found_block;
		logic [STAT_W-1:0] status;
	} out_t;

endpackage

/* rtl/ibmap_mem.sv */
`timescale 1ns / 1ps

module ibmap_mem #(
	parameter int DEPTH = 4236,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port; read data is registered, appears in the cycle after the read and holds until the next read.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ibmap_seq.sv */
`timescale 1ns / 1ps
`include "inode_block_map_top_assert.svh"

module ibmap_seq import ibmap_pkg::*; #(
	parameter int DIRECT_SLOTS  = 12,
	parameter int IDS_PER_TABLE = 64,
	parameter int MAX_ENTRIES   = 4172,
	parameter int ID_WIDTH      = 32,
	localparam int LOG          = $clog2(IDS_PER_TABLE),
	localparam int POOL_TABLES  = IDS_PER_TABLE + 2,
	localparam int PTR_W        = $clog2(POOL_TABLES),
	localparam int MEM_DEPTH    = DIRECT_SLOTS + POOL_TABLES * (1 << LOG),
	localparam int MEM_W        = (ID_WIDTH > PTR_W) ? ID_WIDTH : PTR_W,
	localparam int AW           = $clog2(MEM_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  in_t              req,
	output logic             idle,
	input  logic             res_ready,
	output logic             res_valid,
	output out_t             res,
	output logic             mem_en,
	output logic             mem_we,
	output logic [AW-1:0]    mem_addr,
	output logic [MEM_W-1:0] mem_wdata,
	input  logic [MEM_W-1:0] mem_rdata
);

	localparam int SHAPE_CAP = DIRECT_SLOTS + IDS_PER_TABLE + IDS_PER_TABLE * IDS_PER_TABLE;
	localparam int LIST_CAP  = (MAX_ENTRIES < SHAPE_CAP) ? MAX_ENTRIES : SHAPE_CAP;
	localparam int CNT_W     = $clog2(LIST_CAP + 1);
	localparam int DBL_BASE  = DIRECT_SLOTS + IDS_PER_TABLE;
	localparam int SH        = POS_W + LOG;
	localparam int RECIP     = ((1 << SH) + IDS_PER_TABLE - 1) / IDS_PER_TABLE;
	localparam int RCP_W     = $clog2(RECIP + 1);
	localparam int PROD_W    = POS_W + RCP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_LEAF = 3'd2;
	localparam logic [2:0] S_WR2  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	function automatic logic [AW-1:0] pool_addr(logic [PTR_W-1:0] tbl, logic [LOG-1:0] idx);
		logic [PTR_W+LOG-1:0] off;
		off = {tbl, idx};
		return AW'(DIRECT_SLOTS) + AW'(off);
	endfunction

	function automatic logic [PTR_W-1:0] nf_inc(logic [PTR_W-1:0] t);
		return ((32'(t) + 1) < POOL_TABLES) ? PTR_W'(t + 1'b1) : t;
	endfunction

	logic [2:0]        state_q;
	in_t               req_q;
	logic [LOG-1:0]    quo_q;
	logic [LOG-1:0]    rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PTR_W-1:0]  sgl_q;
	logic [PTR_W-1:0]  dbl_q;
	logic [PTR_W-1:0]  nf_q;
	logic [PTR_W-1:0]  leaf_q;
	logic [LOG-1:0]    jq_q;
	logic [LOG-1:0]    jr_q;
	logic              use_mem_q;
	logic [STAT_W-1:0] status_q;

	logic [POS_W-1:0]  r2_in;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] qfull;
	logic [POS_W-1:0]  r2;
	logic [POS_W-1:0]  qx;
	logic [LOG-1:0]    rem_w;
	logic [31:0]       cnt32;
	logic [31:0]       pos32;
	logic              range_err;
	logic              full;
	logic [PTR_W-1:0]  sgl_tbl;
	logic [PTR_W-1:0]  dbl_tbl;
	logic [PTR_W-1:0]  new_leaf;
	logic [63:0]       nb64;
	logic [63:0]       f64;
	logic [MEM_W-1:0]  nb_word;

	// Quotient of the double-indirect offset by the table size, by reciprocal multiply.
	assign r2_in = req.position - POS_W'(DBL_BASE);
	assign prod  = PROD_W'(r2_in) * PROD_W'(RECIP);
	assign qfull = prod >> SH;

	assign r2    = req_q.position - POS_W'(DBL_BASE);
	assign qx    = POS_W'(quo_q * IDS_PER_TABLE);
	assign rem_w = LOG'(r2 - qx);

	assign cnt32     = 32'(cnt_q);
	assign pos32     = 32'(req_q.position);
	assign range_err = pos32 >= cnt32;
	assign full      = cnt32 >= LIST_CAP;

	assign sgl_tbl  = (cnt32 == DIRECT_SLOTS) ? nf_q : sgl_q;
	assign dbl_tbl  = (cnt32 == DBL_BASE) ? nf_q : dbl_q;
	assign new_leaf = (cnt32 == DBL_BASE) ? nf_inc(nf_q) : nf_q;

	assign nb64    = 64'(req_q.new_block);
	assign nb_word = MEM_W'(nb64[ID_WIDTH-1:0]);
	assign f64     = 64'(mem_rdata[ID_WIDTH-1:0]);

	assign idle            = state_q == S_IDLE;
	assign res_valid       = (state_q == S_FIN) && res_ready;
	assign res.found_block = use_mem_q ? f64[BLK_W-1:0] : '0;
	assign res.status      = status_q;

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		case (state_q)
			S_EXEC: begin
				if (req_q.opcode == OP_LOOKUP) begin
					if (!range_err) begin
						mem_en = 1'b1;
						if (pos32 < DIRECT_SLOTS) begin
							mem_addr = AW'(pos32);
						end else if (pos32 < DBL_BASE) begin
							mem_addr = pool_addr(sgl_q, LOG'(pos32 - DIRECT_SLOTS));
						end else begin
							mem_addr = pool_addr(dbl_q, quo_q);
						end
					end
				end else if (!full) begin
					mem_en = 1'b1;
					mem_we = 1'b1;
					if (cnt32 < DIRECT_SLOTS) begin
						mem_addr  = AW'(cnt32);
						mem_wdata = nb_word;
					end else if (cnt32 < DBL_BASE) begin
						mem_addr  = pool_addr(sgl_tbl, LOG'(cnt32 - DIRECT_SLOTS));
						mem_wdata = nb_word;
					end else if (jr_q == '0) begin
						// A new leaf begins: link it into the top table first.
						mem_addr  = pool_addr(dbl_tbl, jq_q);
						mem_wdata = MEM_W'(new_leaf);
					end else begin
						mem_addr  = pool_addr(leaf_q, jr_q);
						mem_wdata = nb_word;
					end
				end
			end
			S_LEAF: begin
				mem_en   = 1'b1;
				mem_addr = pool_addr(mem_rdata[PTR_W-1:0], rem_q);
			end
			S_WR2: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = pool_addr(leaf_q, '0);
				mem_wdata = nb_word;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			sgl_q   <= '0;
			dbl_q   <= '0;
			nf_q    <= '0;
			leaf_q  <= '0;
			jq_q    <= '0;
			jr_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (req_q.opcode == OP_LOOKUP) begin
						if (!range_err && pos32 >= DBL_BASE) begin
							state_q <= S_LEAF;
						end else begin
							state_q <= S_FIN;
						end
					end else if (!full) begin
						cnt_q <= CNT_W'(cnt_q + 1'b1);
						if (cnt32 == DIRECT_SLOTS) begin
							sgl_q <= nf_q;
							nf_q  <= nf_inc(nf_q);
						end
						if (cnt32 >= DBL_BASE) begin
							if (cnt32 == DBL_BASE) begin
								dbl_q <= nf_q;
							end
							if (jr_q == '0) begin
								leaf_q  <= new_leaf;
								nf_q    <= nf_inc(new_leaf);
								state_q <= S_WR2;
							end else begin
								state_q <= S_FIN;
							end
							if (jr_q == LOG'(IDS_PER_TABLE - 1)) begin
								jr_q <= '0;
								jq_q <= LOG'(jq_q + 1'b1);
							end else begin
								jr_q <= LOG'(jr_q + 1'b1);
							end
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LEAF: state_q <= S_FIN;
				S_WR2:  state_q <= S_FIN;
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && take) begin
			req_q <= req;
			quo_q <= LOG'(qfull);
		end
		if (state_q == S_EXEC) begin
			rem_q <= rem_w;
			if (req_q.opcode == OP_LOOKUP) begin
				status_q  <= range_err ? ST_RANGE : ST_OK;
				use_mem_q <= !range_err;
			end else begin
				status_q  <= full ? ST_FULL : ST_OK;
				use_mem_q <= 1'b0;
			end
		end
	end

	`IBMAP_ASSERT(a_cnt_step, (state_q == S_EXEC && req_q.opcode == OP_APPEND && !full) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)), "entry count did not advance on append")
	`IBMAP_ASSERT(a_leaf_src, (state_q == S_LEAF) |-> ($past(state_q) == S_EXEC), "leaf read not preceded by top table read")
	`IBMAP_NEVER(a_nf_back, nf_q < $past(nf_q), "free table counter moved backward")

endmodule

/* rtl/inode_block_map_top.sv */
`timescale 1ns / 1ps
// Flow: an accepted request is registered and runs through EXEC, then LEAF for a
// double-indirect lookup or WR2 for an append that opens a new leaf table, then FIN.
// A new transaction is taken only once the last has left FIN, which rsp_stall can hold;
// the single-port state memory and the dependent top-table then leaf-table read add states.
// Reset: arst_n clears the count, table pointers and free-table counter; memory contents stay
// undefined and no clearing pass runs, so requests are taken right after reset.

module inode_block_map_top import ibmap_pkg::*; #(
	parameter int DIRECT_SLOTS  = 12,
	parameter int IDS_PER_TABLE = 64,
	parameter int MAX_ENTRIES   = 4172,
	parameter int ID_WIDTH      = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  in_t  req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output out_t rsp
);

	// Memory geometry: direct slots first, then the pointer pool with each table on a
	// power-of-two stride so that a table pointer and an index simply concatenate.
	localparam int LOG         = $clog2(IDS_PER_TABLE);
	localparam int POOL_TABLES = IDS_PER_TABLE + 2;
	localparam int PTR_W       = $clog2(POOL_TABLES);
	localparam int MEM_DEPTH   = DIRECT_SLOTS + POOL_TABLES * (1 << LOG);
	localparam int MEM_W       = (ID_WIDTH > PTR_W) ? ID_WIDTH : PTR_W;
	localparam int AW          = $clog2(MEM_DEPTH);

	logic             idle;
	logic             take;
	logic             res_ready;
	logic             res_valid;
	out_t             res;
	logic             mem_en;
	logic             mem_we;
	logic [AW-1:0]    mem_addr;
	logic [MEM_W-1:0] mem_wdata;
	logic [MEM_W-1:0] mem_rdata;

	logic             rsp_valid_q;
	out_t             rsp_q;

	// The sequencer takes one transaction at a time; it is ready only between items.
	assign req_stall = !idle;
	assign take      = req_valid && idle;

	// The output register may be reloaded when empty or when its transaction leaves this cycle,
	// so a finished result never blocks the sequencer longer than the consumer stalls.
	assign res_ready = !rsp_valid_q || !rsp_stall;

	ibmap_seq #(
		.DIRECT_SLOTS (DIRECT_SLOTS),
		.IDS_PER_TABLE(IDS_PER_TABLE),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.ID_WIDTH     (ID_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.req      (req),
		.idle     (idle),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res      (res),
		.mem_en   (mem_en),
		.mem_we   (mem_we),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	// Holds direct slots, the single-indirect table, the double-indirect top table and leaves.
	ibmap_mem #(
		.DEPTH(MEM_DEPTH),
		.WIDTH(MEM_W)
	) u_mem (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* tb/inode_map_checker.sv */
`timescale 1ns / 1ps

module inode_map_checker import ibmap_pkg::*; #(
	parameter int DIRECT_SLOTS  = 12,
	parameter int IDS_PER_TABLE = 64,
	parameter int MAX_ENTRIES   = 4172,
	parameter int ID_WIDTH      = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  in_t  req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  out_t rsp,
	output int   fail_count,
	output int   pending,
	output int   appends_seen,
	output int   full_seen,
	output int   lookups_seen,
	output int   range_seen
);

	localparam int POOL_TABLES = 2 + IDS_PER_TABLE;
	localparam int TBL_W       = $clog2(POOL_TABLES);
	localparam int POOL_AW     = $clog2(POOL_TABLES * IDS_PER_TABLE);
	localparam int DIR_AW      = $clog2(DIRECT_SLOTS);
	localparam int SHAPE_CAP   = DIRECT_SLOTS + IDS_PER_TABLE + IDS_PER_TABLE * IDS_PER_TABLE;
	localparam int LIST_CAP    = (MAX_ENTRIES < SHAPE_CAP) ? MAX_ENTRIES : SHAPE_CAP;
	localparam int KEEP_W      = (ID_WIDTH < BLK_W) ? ID_WIDTH : BLK_W;
	localparam logic [BLK_W-1:0] ID_MASK = {BLK_W{1'b1}} >> (BLK_W - KEEP_W);

	// Shadow copy of the map: direct slots, the table pool and the pointers into it.
	bit [BLK_W-1:0] direct_ids [DIRECT_SLOTS];
	bit [BLK_W-1:0] table_pool [POOL_TABLES * IDS_PER_TABLE];
	bit [POS_W:0]   entry_cnt;
	bit [TBL_W-1:0] single_tbl;
	bit [TBL_W-1:0] double_tbl;
	bit [TBL_W-1:0] next_tbl;

	out_t due_answers [$];

	function automatic bit [BLK_W-1:0] pool_rd(bit [BLK_W-1:0] tbl, int unsigned slot);
		if (tbl >= POOL_TABLES || slot >= IDS_PER_TABLE)
			return '0;
		return table_pool[POOL_AW'(tbl * IDS_PER_TABLE + slot)];
	endfunction

	function automatic void pool_wr(bit [BLK_W-1:0] tbl, int unsigned slot, bit [BLK_W-1:0] val);
		if (tbl < POOL_TABLES && slot < IDS_PER_TABLE)
			table_pool[POOL_AW'(tbl * IDS_PER_TABLE + slot)] = val;
	endfunction

	// Tables are handed out in order; the counter sticks at the last one.
	function automatic bit [TBL_W-1:0] grab_table();
		bit [TBL_W-1:0] t;
		t = next_tbl;
		if (next_tbl + 1 < POOL_TABLES)
			next_tbl++;
		return t;
	endfunction

	// Applies one request to the shadow map and returns the answer it must produce.
	function automatic out_t predict_map_answer(in_t item);
		out_t           ans;
		int unsigned    slot;
		bit [BLK_W-1:0] leaf;
		bit [BLK_W-1:0] nb;
		ans = '0;
		ans.status = ST_OK;
		nb = item.new_block & ID_MASK;
		if (item.opcode == OP_LOOKUP) begin
			slot = 32'(item.position);
			if (slot >= entry_cnt) begin
				ans.status = ST_RANGE;
			end else if (slot < DIRECT_SLOTS) begin
				ans.found_block = direct_ids[DIR_AW'(slot)];
			end else begin
				slot -= DIRECT_SLOTS;
				if (slot < IDS_PER_TABLE) begin
					ans.found_block = pool_rd(BLK_W'(single_tbl), slot);
				end else begin
					slot -= IDS_PER_TABLE;
					leaf = pool_rd(BLK_W'(double_tbl), slot / IDS_PER_TABLE);
					ans.found_block = pool_rd(leaf, slot % IDS_PER_TABLE);
				end
			end
		end else if (entry_cnt >= LIST_CAP) begin
			ans.status = ST_FULL;
		end else begin
			slot = 32'(entry_cnt);
			entry_cnt++;
			if (slot < DIRECT_SLOTS) begin
				direct_ids[DIR_AW'(slot)] = nb;
			end else begin
				slot -= DIRECT_SLOTS;
				if (slot == 0)
					single_tbl = grab_table();
				if (slot < IDS_PER_TABLE) begin
					pool_wr(BLK_W'(single_tbl), slot, nb);
				end else begin
					slot -= IDS_PER_TABLE;
					if (slot == 0)
						double_tbl = grab_table();
					if (slot % IDS_PER_TABLE == 0) begin
						leaf = BLK_W'(grab_table());
						pool_wr(BLK_W'(double_tbl), slot / IDS_PER_TABLE, leaf);
					end else begin
						leaf = pool_rd(BLK_W'(double_tbl), slot / IDS_PER_TABLE);
					end
					pool_wr(leaf, slot % IDS_PER_TABLE, nb);
				end
			end
		end
		return ans;
	endfunction

	// Responses are checked before the request of the same edge is queued; the
	// block's latency keeps the two from ever being the same transaction.
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			entry_cnt = '0;
			single_tbl = '0;
			double_tbl = '0;
			next_tbl = '0;
			due_answers.delete();
			fail_count = 0;
			pending = 0;
			appends_seen = 0;
			full_seen = 0;
			lookups_seen = 0;
			range_seen = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_answers.size() == 0) begin
					$error("Response with nothing outstanding: found_block %0h status %0d",
						rsp.found_block, rsp.status);
					fail_count++;
				end else begin
					want = due_answers.pop_front();
					if (rsp.found_block !== want.found_block) begin
						$error("found_block mismatch: expected %0h, actual %0h",
							want.found_block, rsp.found_block);
						fail_count++;
					end
					if (rsp.status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, rsp.status);
						fail_count++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				want = predict_map_answer(req);
				due_answers.push_back(want);
				if (req.opcode == OP_APPEND) begin
					appends_seen++;
					if (want.status == ST_FULL)
						full_seen++;
				end else begin
					lookups_seen++;
					if (want.status == ST_RANGE)
						range_seen++;
				end
			end
			pending = due_answers.size();
		end
	end

endmodule

/* tb/tb_inode_block_map_top.sv */
`timescale 1ns / 1ps

module tb_inode_block_map_top;

	import ibmap_pkg::*;

	localparam int DIRECT_SLOTS  = 12;
	localparam int IDS_PER_TABLE = 64;
	localparam int MAX_ENTRIES   = 4172;
	localparam int ID_WIDTH      = 32;

	// The map holds the lesser of MAX_ENTRIES and what the three regions can address.
	localparam int SHAPE_CAP = DIRECT_SLOTS + IDS_PER_TABLE + IDS_PER_TABLE * IDS_PER_TABLE;
	localparam int LIST_CAP  = (MAX_ENTRIES < SHAPE_CAP) ? MAX_ENTRIES : SHAPE_CAP;
	localparam int POS_TOP   = LIST_CAP - 1;
	localparam int DOUBLE_START = DIRECT_SLOTS + IDS_PER_TABLE;

	// Upper bound on run time for about 1800 transactions, even under heavy stalling.
	localparam int CYCLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	in_t  req;
	logic rsp_valid;
	logic rsp_stall;
	out_t rsp;

	int fail_count;
	int pending;
	int appends_seen;
	int full_seen;
	int lookups_seen;
	int range_seen;

	// Idle rates in percent for the request and response sides, and the length of
	// a response hold-off that the receiver process counts down on its own.
	int tx_pct;
	int rx_pct;
	int hold_cycles;

	// Number of entries the stimulus has put in the map; used to aim lookups and in the final report.
	int filled;
	int cycle_cnt;

	always #2 clk = ~clk;

	inode_block_map_top #(
		.DIRECT_SLOTS (DIRECT_SLOTS),
		.IDS_PER_TABLE(IDS_PER_TABLE),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.ID_WIDTH     (ID_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	inode_map_checker #(
		.DIRECT_SLOTS (DIRECT_SLOTS),
		.IDS_PER_TABLE(IDS_PER_TABLE),
		.MAX_ENTRIES  (MAX_ENTRIES),
		.ID_WIDTH     (ID_WIDTH)
	) checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.pending     (pending),
		.appends_seen(appends_seen),
		.full_seen   (full_seen),
		.lookups_seen(lookups_seen),
		.range_seen  (range_seen)
	);

	// Response side. Each cycle it either stalls at the current idle rate or, when a
	// hold-off has been requested, keeps stall high until that count runs out. A long
	// hold-off backs the block up until it stalls its own request side.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else begin
				rsp_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
			end
		end
	end

	// Runaway guard: if the run has not finished by the limit, something hung.
	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offers one transaction and returns at the edge where it is taken. Valid stays
	// high into the next call unless an idle gap is chosen here, so the next call
	// never lowers and raises it in one time step.
	task automatic send_item(input in_t item);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (item.opcode == OP_APPEND && filled < LIST_CAP)
			filled++;
		if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	// Ids lean toward the all-zeros and all-ones extremes now and then.
	function automatic logic [BLK_W-1:0] pick_block();
		int unsigned k;
		k = $urandom_range(19);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		return $urandom();
	endfunction

	// Lookup positions: mostly inside the filled part, some on region edges and on
	// the current end of the list, the rest anywhere in the legal range.
	function automatic logic [POS_W-1:0] pick_position();
		int unsigned k;
		int p;
		k = $urandom_range(99);
		if (k < 65 && filled > 0) begin
			p = $urandom_range(filled - 1, 0);
		end else if (k < 85) begin
			case ($urandom_range(5))
				0: p = filled;
				1: p = (filled > 0) ? filled - 1 : 0;
				2: p = DIRECT_SLOTS - 1 + $urandom_range(1);
				3: p = DOUBLE_START - 1 + $urandom_range(1);
				4: p = DOUBLE_START + $urandom_range(IDS_PER_TABLE - 1) * IDS_PER_TABLE
					- $urandom_range(1);
				default: p = POS_TOP;
			endcase
		end else begin
			p = $urandom_range(POS_TOP);
		end
		if (p > POS_TOP)
			p = POS_TOP;
		return POS_W'(p);
	endfunction

	task automatic do_lookup(input int pos);
		in_t item;
		item.opcode = OP_LOOKUP;
		item.position = POS_W'(pos);
		item.new_block = $urandom();
		send_item(item);
	endtask

	task automatic do_append(input logic [BLK_W-1:0] blk);
		in_t item;
		item.opcode = OP_APPEND;
		item.position = POS_W'($urandom_range(POS_TOP));
		item.new_block = blk;
		send_item(item);
	endtask

	// The field that an operation ignores is always random, so new_block sees every bit
	// pattern and position every legal value regardless of the opcode mix.
	task automatic send_random(input int append_pct);
		if ($urandom_range(99) < append_pct)
			do_append(pick_block());
		else
			do_lookup(pick_position());
	endtask

	initial begin
		int i;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		tx_pct = 28;
		rx_pct = 61;
		hold_cycles = 0;
		filled = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Lookups on the empty map, both id extremes, reads at and
		// past the end, and the step from the last direct slot into the single table.
		do_lookup(0);
		do_lookup(POS_TOP);
		do_append('0);
		do_append('1);
		do_lookup(0);
		do_lookup(1);
		do_lookup(2);
		for (i = 0; i < DIRECT_SLOTS - 1; i++)
			do_append(pick_block());
		do_lookup(DIRECT_SLOTS - 1);
		do_lookup(DIRECT_SLOTS);
		do_lookup(DIRECT_SLOTS + 1);

		// Random traffic in three idle patterns. Appends outnumber lookups so the map
		// grows well into the double-indirect region while its contents are read back.
		for (i = 0; i < 590; i++)
			send_random(60);
		tx_pct = 61;
		rx_pct = 28;
		for (i = 0; i < 590; i++)
			send_random(60);
		tx_pct = 0;
		rx_pct = 0;
		hold_cycles = 200;
		for (i = 0; i < 590; i++)
			send_random(60);

		// Close with appends of both id extremes and reads of the far corners.
		do_append('0);
		do_append('1);
		do_append(pick_block());
		do_lookup(POS_TOP);
		do_lookup(POS_TOP - 1);
		do_lookup(0);
		do_lookup(DOUBLE_START - 1);
		do_lookup(DOUBLE_START);
		req_valid <= 1'b0;

		// Drain, then keep the clock running so that any stray response shows.
		do
			@(posedge clk);
		while (pending != 0);
		repeat (16) @(posedge clk);

		$display("Ran %0d appends (%0d refused as full) and %0d lookups (%0d past the end).",
			appends_seen, full_seen, lookups_seen, range_seen);
		$display("The map ended with %0d of %0d entries in use.", filled, LIST_CAP);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
